### rtl/core/ibp_pkg.sv
// Types, constants and the opcode mode lookup for the instruction boundary predecoder.
// Used by every module under rtl/core; depends on nothing.
package ibp_pkg;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic [15:0] byte_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  prefix_page;
    logic [7:0]  opcode_value;
    logic [3:0]  addr_mode;
    logic [7:0]  operand_byte;
    logic [15:0] operand_word;
    logic [7:0]  index_postbyte;
    logic [15:0] branch_target;
  } out_item_t;

  typedef enum logic [3:0] {
    MODE_ILLEGAL  = 4'd0,
    MODE_INHERENT = 4'd1,
    MODE_IMM8     = 4'd2,
    MODE_IMM16    = 4'd3,
    MODE_DIRECT   = 4'd4,
    MODE_EXTENDED = 4'd5,
    MODE_INDEXED  = 4'd6,
    MODE_REL      = 4'd7,
    MODE_LONGREL  = 4'd8,
    MODE_STACK_S  = 4'd9,
    MODE_STACK_U  = 4'd10,
    MODE_REGPAIR  = 4'd11
  } addr_mode_e;

  typedef enum logic [3:0] {
    PH_OPCODE  = 4'b0001,
    PH_BYTE    = 4'b0010,
    PH_WORD_HI = 4'b0100,
    PH_WORD_LO = 4'b1000
  } phase_e;

  localparam logic [1:0] PAGE_NONE = 2'd0;
  localparam logic [1:0] PAGE_10   = 2'd1;
  localparam logic [1:0] PAGE_11   = 2'd2;

  localparam logic [7:0] PREFIX_10 = 8'h10;
  localparam logic [7:0] PREFIX_11 = 8'h11;

  localparam logic [3:0] PAGE0_MODES [256] = '{
    4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4,
    4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4,
    4'h0, 4'h0, 4'h1, 4'h1, 4'h0, 4'h0, 4'h8, 4'h8,
    4'h0, 4'h1, 4'h2, 4'h0, 4'h2, 4'h1, 4'hb, 4'hb,
    4'h7, 4'h7, 4'h7, 4'h7, 4'h7, 4'h7, 4'h7, 4'h7,
    4'h7, 4'h7, 4'h7, 4'h7, 4'h7, 4'h7, 4'h7, 4'h7,
    4'h6, 4'h6, 4'h6, 4'h6, 4'h9, 4'h9, 4'ha, 4'ha,
    4'h0, 4'h1, 4'h1, 4'h1, 4'h2, 4'h1, 4'h0, 4'h1,
    4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1,
    4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h0, 4'h1,
    4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1,
    4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h0, 4'h1,
    4'h6, 4'h0, 4'h0, 4'h6, 4'h6, 4'h0, 4'h6, 4'h6,
    4'h6, 4'h6, 4'h6, 4'h0, 4'h6, 4'h6, 4'h6, 4'h6,
    4'h5, 4'h0, 4'h0, 4'h5, 4'h5, 4'h0, 4'h5, 4'h5,
    4'h5, 4'h5, 4'h5, 4'h0, 4'h5, 4'h5, 4'h5, 4'h5,
    4'h2, 4'h2, 4'h2, 4'h3, 4'h2, 4'h2, 4'h2, 4'h0,
    4'h2, 4'h2, 4'h2, 4'h2, 4'h3, 4'h7, 4'h3, 4'h0,
    4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4,
    4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4,
    4'h6, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6,
    4'h6, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6,
    4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5,
    4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5,
    4'h2, 4'h2, 4'h2, 4'h3, 4'h2, 4'h2, 4'h2, 4'h0,
    4'h2, 4'h2, 4'h2, 4'h2, 4'h3, 4'h0, 4'h3, 4'h0,
    4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4,
    4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4,
    4'h6, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6,
    4'h6, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6,
    4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5,
    4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5
  };

  // Upper half of the prefixed pages: mode follows the row group.
  function automatic addr_mode_e row_mode(input logic [1:0] grp);
    addr_mode_e m;
    case (grp)
      2'd0:    m = MODE_IMM16;
      2'd1:    m = MODE_DIRECT;
      2'd2:    m = MODE_INDEXED;
      default: m = MODE_EXTENDED;
    endcase
    return m;
  endfunction

  function automatic addr_mode_e lookup_mode(input logic [1:0] page, input logic [7:0] op);
    logic [3:0] lo;
    logic [3:0] hi;
    addr_mode_e rm;
    addr_mode_e m;
    lo = op[3:0];
    hi = op[7:4];
    rm = row_mode(hi[1:0]);
    m  = MODE_ILLEGAL;
    case (page)
      PAGE_10: begin
        if (op >= 8'h21 && op <= 8'h2f) begin
          m = MODE_LONGREL;
        end else if (op == 8'h3f) begin
          m = MODE_INHERENT;
        end else if (op >= 8'h80 && op < 8'hc0) begin
          if (lo == 4'h3 || lo == 4'hc || lo == 4'he) m = rm;
          else if (lo == 4'hf && hi != 4'h8) m = rm;
        end else if (op >= 8'hc0) begin
          if (lo == 4'he) m = rm;
          else if (lo == 4'hf && hi != 4'hc) m = rm;
        end
      end
      PAGE_11: begin
        if (op == 8'h3f) begin
          m = MODE_INHERENT;
        end else if (op >= 8'h80 && op < 8'hc0 && (lo == 4'h3 || lo == 4'hc)) begin
          m = rm;
        end
      end
      default: m = addr_mode_e'(PAGE0_MODES[op]);
    endcase
    return m;
  endfunction

endpackage

### rtl/core/instruction_boundary_predecoder_unit.sv
// Top level of the instruction boundary predecoder.
// Input register, decode logic, result register. A completed instruction's record is
// loaded into the result register when its last byte is decoded.
// Throughput is one byte per cycle while the consumer keeps up.
// Reset clears the pipeline valid bits and all instruction state to the opcode phase.
// Depends on ibp_pkg, ibp_in_stage, ibp_decode and ibp_out_stage.
module instruction_boundary_predecoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ibp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ibp_pkg::out_item_t out_item_o
);
  import ibp_pkg::*;

  logic      dec_ready;
  logic      advance;
  logic      done;
  in_item_t  item;
  out_item_t rec;

  ibp_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .dec_ready_i (dec_ready),
    .advance_o   (advance),
    .item_o      (item)
  );

  ibp_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .done_o    (done),
    .rec_o     (rec)
  );

  ibp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance & done),
    .rec_i       (rec),
    .ready_o     (dec_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### rtl/core/ibp_in_stage.sv
// Input register of the predecoder: holds one accepted byte until the decoder takes it.
// Depends on ibp_pkg.
module ibp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ibp_pkg::in_item_t in_item_i,
  input  logic              dec_ready_i,
  output logic              advance_o,
  output ibp_pkg::in_item_t item_o
);
  import ibp_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  assign advance_o  = valid_q & dec_ready_i;
  assign in_stall_o = valid_q & ~dec_ready_i;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

### rtl/core/ibp_decode.sv
// Instruction state and per-byte decode: prefix pages, mode lookup, operand gathering,
// branch target. Depends on ibp_pkg.
module ibp_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  ibp_pkg::in_item_t  item_i,
  output logic               done_o,
  output ibp_pkg::out_item_t rec_o
);
  import ibp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  page_q, page_d;
  addr_mode_e  mode_q, mode_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [7:0]  byte_q, byte_d;
  logic [15:0] word_q, word_d;
  logic [7:0]  postbyte_q, postbyte_d;
  logic        done;
  logic [7:0]  b;
  logic [15:0] target;

  assign b = item_i.code_byte;

  always_comb begin
    phase_d    = phase_q;
    page_d     = page_q;
    mode_d     = mode_q;
    opcode_d   = opcode_q;
    byte_d     = byte_q;
    word_d     = word_q;
    postbyte_d = postbyte_q;
    done       = 1'b0;

    case (phase_q)
      PH_BYTE: begin
        if (mode_q == MODE_INDEXED && postbyte_q == 8'h00) begin
          postbyte_d = b;
          if (!b[7]) begin
            done = 1'b1;
          end else begin
            case (b[3:0])
              4'h8, 4'hc:       phase_d = PH_BYTE;
              4'h9, 4'hd, 4'hf: phase_d = PH_WORD_HI;
              default:          done = 1'b1;
            endcase
          end
        end else begin
          byte_d = b;
          done   = 1'b1;
        end
      end
      PH_WORD_HI: begin
        word_d  = {8'h00, b};
        phase_d = PH_WORD_LO;
      end
      PH_WORD_LO: begin
        word_d = {word_q[7:0], b};
        done   = 1'b1;
      end
      default: begin
        opcode_d = b;
        phase_d  = PH_OPCODE;
        if (page_q == PAGE_NONE && (b == PREFIX_10 || b == PREFIX_11)) begin
          page_d = (b == PREFIX_10) ? PAGE_10 : PAGE_11;
          mode_d = MODE_ILLEGAL;
        end else begin
          mode_d = lookup_mode(page_q, b);
          case (mode_d)
            MODE_IMM16, MODE_EXTENDED, MODE_LONGREL: phase_d = PH_WORD_HI;
            MODE_ILLEGAL, MODE_INHERENT:             done = 1'b1;
            default:                                 phase_d = PH_BYTE;
          endcase
        end
      end
    endcase

    case (mode_d)
      MODE_REL:     target = item_i.byte_address + 16'd1 + {{8{byte_d[7]}}, byte_d};
      MODE_LONGREL: target = item_i.byte_address + 16'd1 + word_d;
      default:      target = 16'h0000;
    endcase

    rec_o.prefix_page    = page_d;
    rec_o.opcode_value   = opcode_d;
    rec_o.addr_mode      = mode_d;
    rec_o.operand_byte   = byte_d;
    rec_o.operand_word   = word_d;
    rec_o.index_postbyte = (mode_d == MODE_INDEXED) ? postbyte_d : 8'h00;
    rec_o.branch_target  = target;

    if (done) begin
      postbyte_d = 8'h00;
      phase_d    = PH_OPCODE;
      page_d     = PAGE_NONE;
    end
  end

  assign done_o = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_OPCODE;
      page_q     <= PAGE_NONE;
      mode_q     <= MODE_ILLEGAL;
      opcode_q   <= 8'h00;
      byte_q     <= 8'h00;
      word_q     <= 16'h0000;
      postbyte_q <= 8'h00;
    end else if (advance_i) begin
      phase_q    <= phase_d;
      page_q     <= page_d;
      mode_q     <= mode_d;
      opcode_q   <= opcode_d;
      byte_q     <= byte_d;
      word_q     <= word_d;
      postbyte_q <= postbyte_d;
    end
  end

endmodule

### rtl/core/ibp_out_stage.sv
// Result register of the predecoder: holds one decoded record until the consumer takes it.
// Depends on ibp_pkg.
module ibp_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ibp_pkg::out_item_t rec_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ibp_pkg::out_item_t out_item_o
);
  import ibp_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  assign ready_o     = ~valid_q | ~out_stall_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= rec_i;
    end
  end

endmodule
